@@ rtl/csw_pkg.sv @@
// Shared types and constants of the CPU schedule wait-time block.
`default_nettype none
package csw_pkg;
	localparam int MODE_W = 2;
	localparam int QUANT_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int WAIT_W = 21;
	localparam int TOT_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b1;

	localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RR   = 2'd3;

	typedef struct packed {
		logic [15:0] burst;
		logic [7:0]  prio;
		logic        last_proc;
	} in_t;

	typedef struct packed {
		logic [3:0]  slot;
		logic [15:0] proc_burst;
		logic [19:0] wait_res;
		logic [19:0] turnaround;
		logic [23:0] total_wait;
		logic [23:0] total_turnaround;
		logic        overflow;
		logic        last_result;
	} out_t;
endpackage
`default_nettype wire

@@ rtl/cpu_schedule_wait_times_top.sv @@
// Top level of the CPU schedule wait-time block: load, sort or round robin as the mode asks, report.
// Requests load while idle; the last request starts a walk limited by the single RAM read
// port: one selection pass per sort position, or a setup pass and then round-robin passes
// over the entries, then one result at a time, each held until it is taken.
// Throughput: one set at a time; input is held off until the last result leaves.
// Reset (arst_n low) clears count, drop flag, mode (0) and quantum (1); RAMs are not cleared.
`default_nettype none
module cpu_schedule_wait_times_top #(
	parameter int MAX_PROCS  = 16,
	parameter int BURST_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire csw_pkg::in_t                in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output csw_pkg::out_t                    out_data,
	input  wire logic                        cfg_we,
	input  wire logic [csw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [csw_pkg::QUANT_W-1:0] cfg_data
);
	import csw_pkg::*;

	localparam int IDX_W = $clog2(MAX_PROCS);
	localparam int CNT_W = $clog2(MAX_PROCS + 1);
	localparam int SB    = (BURST_BITS < 16) ? BURST_BITS : 16;
	localparam int BP_W  = SB + 8;
	localparam int RW_W  = SB + WAIT_W;

	// sequencer codes
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LDI   = 4'd1;
	localparam logic [3:0] ST_CAPI  = 4'd2;
	localparam logic [3:0] ST_RDJ   = 4'd3;
	localparam logic [3:0] ST_CMPJ  = 4'd4;
	localparam logic [3:0] ST_WRI   = 4'd5;
	localparam logic [3:0] ST_RI_RD = 4'd6;
	localparam logic [3:0] ST_RI_WR = 4'd7;
	localparam logic [3:0] ST_RR_RD = 4'd8;
	localparam logic [3:0] ST_RR_EX = 4'd9;
	localparam logic [3:0] ST_O_RD  = 4'd10;
	localparam logic [3:0] ST_O_CAL = 4'd11;
	localparam logic [3:0] ST_O_WT  = 4'd12;

	logic [3:0]         st_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               drop_q;
	logic [MODE_W-1:0]  mode_q;
	logic [QUANT_W-1:0] quant_q;
	logic [IDX_W-1:0]   k_q, i_q;
	logic [BP_W-1:0]    ci_q;
	logic               any_q;
	logic [WAIT_W-1:0]  clk_q;
	logic [WAIT_W-1:0]  prefix_q;
	logic [TOT_W-1:0]   tw_q, tt_q;

	// process RAM {prio, burst} and round-robin RAM {remaining, wait}
	logic             bp_we, rw_we;
	logic [IDX_W-1:0] bp_waddr, bp_raddr, rw_raddr;
	logic [BP_W-1:0]  bp_wdata, bp_rdata;
	logic [RW_W-1:0]  rw_wdata, rw_rdata;

	csw_ram #(.WIDTH(BP_W), .DEPTH(MAX_PROCS)) u_bp_ram (
		.clk(clk), .we(bp_we), .waddr(bp_waddr), .wdata(bp_wdata),
		.raddr(bp_raddr), .rdata(bp_rdata)
	);
	csw_ram #(.WIDTH(RW_W), .DEPTH(MAX_PROCS)) u_rw_ram (
		.clk(clk), .we(rw_we), .waddr(k_q), .wdata(rw_wdata),
		.raddr(rw_raddr), .rdata(rw_rdata)
	);

	logic             in_acc, store_ok;
	logic [IDX_W-1:0] last_idx;
	logic [SB-1:0]    rd_burst, ci_burst, rem;
	logic [7:0]       rd_prio, ci_prio;
	logic             swap;
	logic [QUANT_W-1:0] q_eff;
	logic             rem_gt_q;
	logic [WAIT_W-1:0] clk_nx;
	logic [WAIT_W-1:0] w_cur;
	logic [21:0]       ta_cur;

	assign in_ready = (st_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign store_ok = (cnt_q < CNT_W'(MAX_PROCS));
	assign last_idx = IDX_W'(cnt_q - CNT_W'(1));
	assign rd_burst = bp_rdata[SB-1:0];
	assign rd_prio  = bp_rdata[BP_W-1:SB];
	assign ci_burst = ci_q[SB-1:0];
	assign ci_prio  = ci_q[BP_W-1:SB];
	assign swap     = (mode_q == MODE_PRIO) ? (ci_prio > rd_prio) : (ci_burst > rd_burst);
	assign q_eff    = (quant_q == '0) ? QUANT_W'(1) : quant_q;
	assign rem      = rw_rdata[RW_W-1:WAIT_W];
	assign rem_gt_q = (17'(rem) > 17'(q_eff));
	assign clk_nx   = rem_gt_q ? clk_q + WAIT_W'(q_eff) : clk_q + WAIT_W'(rem);
	assign w_cur    = (mode_q == MODE_RR) ? rw_rdata[WAIT_W-1:0] : prefix_q;
	assign ta_cur   = 22'(w_cur) + 22'(rd_burst);

	// RAM port steering: reads on the walk index (position i while loading it), writes per phase
	always_comb begin
		bp_we    = 1'b0;
		bp_waddr = k_q;
		bp_wdata = '0;
		bp_raddr = k_q;
		rw_raddr = k_q;
		rw_we    = 1'b0;
		rw_wdata = {rem, rw_rdata[WAIT_W-1:0]};
		unique case (st_q)
			ST_IDLE: begin
				bp_we    = in_acc && store_ok;
				bp_waddr = IDX_W'(cnt_q);
				bp_wdata = {in_data.prio, in_data.burst[SB-1:0]};
			end
			ST_LDI: bp_raddr = i_q;
			ST_CMPJ: begin
				bp_we    = swap;
				bp_wdata = ci_q;
			end
			ST_WRI: begin
				bp_we    = 1'b1;
				bp_waddr = i_q;
				bp_wdata = ci_q;
			end
			ST_RI_WR: begin
				rw_we    = 1'b1;
				rw_wdata = {rd_burst, WAIT_W'(0)};
			end
			ST_RR_EX: begin
				rw_we = (rem != '0);
				if (rem_gt_q) begin
					rw_wdata = {SB'(rem - SB'(q_eff)), rw_rdata[WAIT_W-1:0]};
				end else begin
					rw_wdata = {SB'(0), clk_nx - WAIT_W'(rd_burst)};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_FCFS;
			quant_q <= QUANT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:    mode_q  <= cfg_data[MODE_W-1:0];
				CFG_QUANTUM: quant_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			cnt_q     <= '0;
			drop_q    <= 1'b0;
			out_valid <= 1'b0;
			out_data  <= '0;
			k_q       <= '0;
			i_q       <= '0;
			any_q     <= 1'b0;
			clk_q     <= '0;
			prefix_q  <= '0;
			tw_q      <= '0;
			tt_q      <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (store_ok) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (in_data.last_proc) begin
							k_q      <= '0;
							i_q      <= '0;
							prefix_q <= '0;
							tw_q     <= '0;
							tt_q     <= '0;
							clk_q    <= '0;
							any_q    <= 1'b0;
							priority if (mode_q == MODE_RR) st_q <= ST_RI_RD;
							else if (mode_q == MODE_FCFS) st_q <= ST_O_RD;
							// a single stored process needs no sort
							else if (store_ok ? (cnt_q == '0) : (cnt_q == CNT_W'(1)))
								st_q <= ST_O_RD;
							else st_q <= ST_LDI;
						end
					end
				end
				ST_LDI: st_q <= ST_CAPI;
				ST_CAPI: begin
					k_q  <= i_q + IDX_W'(1);
					st_q <= ST_RDJ;
				end
				ST_RDJ: st_q <= ST_CMPJ;
				ST_CMPJ: begin
					if (k_q == last_idx) begin
						st_q <= ST_WRI;
					end else begin
						k_q  <= k_q + IDX_W'(1);
						st_q <= ST_RDJ;
					end
				end
				ST_WRI: begin
					if (i_q + IDX_W'(1) == last_idx) begin
						k_q  <= '0;
						st_q <= ST_O_RD;
					end else begin
						i_q  <= i_q + IDX_W'(1);
						st_q <= ST_LDI;
					end
				end
				ST_RI_RD: st_q <= ST_RI_WR;
				ST_RI_WR: begin
					if (k_q == last_idx) begin
						k_q  <= '0;
						st_q <= ST_RR_RD;
					end else begin
						k_q  <= k_q + IDX_W'(1);
						st_q <= ST_RI_RD;
					end
				end
				ST_RR_RD: st_q <= ST_RR_EX;
				ST_RR_EX: begin
					if (rem != '0) begin
						clk_q <= clk_nx;
					end
					if (k_q == last_idx) begin
						k_q   <= '0;
						any_q <= 1'b0;
						// another pass while any process still had work
						st_q  <= (any_q || rem != '0) ? ST_RR_RD : ST_O_RD;
					end else begin
						k_q   <= k_q + IDX_W'(1);
						any_q <= any_q || (rem != '0);
						st_q  <= ST_RR_RD;
					end
				end
				ST_O_RD: st_q <= ST_O_CAL;
				ST_O_CAL: begin
					out_data.slot             <= 4'(k_q);
					out_data.proc_burst       <= 16'(rd_burst);
					out_data.wait_res         <= w_cur[19:0];
					out_data.turnaround       <= ta_cur[19:0];
					out_data.total_wait       <= tw_q + TOT_W'(w_cur);
					out_data.total_turnaround <= tt_q + TOT_W'(ta_cur);
					out_data.overflow         <= drop_q;
					out_data.last_result      <= (k_q == last_idx);
					tw_q      <= tw_q + TOT_W'(w_cur);
					tt_q      <= tt_q + TOT_W'(ta_cur);
					prefix_q  <= prefix_q + WAIT_W'(rd_burst);
					out_valid <= 1'b1;
					st_q      <= ST_O_WT;
				end
				ST_O_WT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (k_q == last_idx) begin
							cnt_q  <= '0;
							drop_q <= 1'b0;
							st_q   <= ST_IDLE;
						end else begin
							k_q  <= k_q + IDX_W'(1);
							st_q <= ST_O_RD;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// sort register for position i: capture, then swap with smaller later keys
	always_ff @(posedge clk) begin
		if (st_q == ST_CAPI) begin
			ci_q <= bp_rdata;
		end else if (st_q == ST_CMPJ && swap) begin
			ci_q <= bp_rdata;
		end
	end

	a_valid_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> st_q == ST_O_WT)
		else $error("result shown outside the wait state");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_PROCS))
		else $error("process count beyond capacity");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last_result |=> cnt_q == '0 && !drop_q)
		else $error("set state not cleared after final result");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(k_q))
		else $error("walk index moved while a result waits");
endmodule
`default_nettype wire

@@ rtl/csw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module csw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ dv/cpu_schedule_wait_times_top_tb.sv @@
// Self-checking testbench for the CPU schedule wait-time block.
`default_nettype none
module cpu_schedule_wait_times_top_tb;
	import csw_pkg::*;

	localparam int PROC_CAP = 16;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [QUANT_W-1:0] cfg_data;

	cpu_schedule_wait_times_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Requests waiting to be offered, and schedule results still owed by the block.
	in_t proc_q[$];
	out_t sched_expect_q[$];

	// Shadow of the block: loaded processes, count, drop flag and registers.
	logic [15:0] sh_burst[PROC_CAP];
	logic [7:0] sh_prio[PROC_CAP];
	int sh_count;
	bit sh_dropped;
	logic [MODE_W-1:0] sh_mode;
	logic [QUANT_W-1:0] sh_quantum;

	int errors;
	int items_sent;
	bit quiet;          // no idling on either side once set
	bit long_hold_req;  // ask the receiver for one long hold-off
	int send_gap;
	int recv_hold;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Load one accepted request into the shadow; the last one of a set
	// produces every expected result of that set.
	task automatic sched_predict(input in_t req);
		logic [20:0] wait_v[PROC_CAP];
		logic [15:0] remain[PROC_CAP];
		logic [20:0] rr_clk;
		logic [63:0] prefix, tw, tt;
		logic [15:0] tb;
		logic [7:0] tp;
		logic [16:0] q;
		logic [20:0] ta;
		bit swap, busy;
		out_t r;
		if (sh_count < PROC_CAP) begin
			sh_burst[sh_count] = req.burst;
			sh_prio[sh_count] = req.prio;
			sh_count++;
		end else begin
			sh_dropped = 1'b1;
		end
		if (!req.last_proc)
			return;
		// Exchange sort: each later entry with a strictly smaller key is swapped in.
		if (sh_mode == MODE_SJF || sh_mode == MODE_PRIO) begin
			for (int i = 0; i + 1 < sh_count; i++) begin
				for (int j = i + 1; j < sh_count; j++) begin
					swap = (sh_mode == MODE_SJF) ? (sh_burst[i] > sh_burst[j])
						: (sh_prio[i] > sh_prio[j]);
					if (swap) begin
						tb = sh_burst[i];
						sh_burst[i] = sh_burst[j];
						sh_burst[j] = tb;
						tp = sh_prio[i];
						sh_prio[i] = sh_prio[j];
						sh_prio[j] = tp;
					end
				end
			end
		end
		if (sh_mode == MODE_RR) begin
			q = (sh_quantum == '0) ? 17'd1 : {1'b0, sh_quantum};
			rr_clk = '0;
			for (int i = 0; i < sh_count; i++) begin
				remain[i] = sh_burst[i];
				wait_v[i] = '0;
			end
			busy = 1'b1;
			while (busy) begin
				busy = 1'b0;
				for (int i = 0; i < sh_count; i++) begin
					if (remain[i] != 0) begin
						busy = 1'b1;
						if ({1'b0, remain[i]} > q) begin
							rr_clk = rr_clk + q;
							remain[i] = remain[i] - q[15:0];
						end else begin
							rr_clk = rr_clk + remain[i];
							wait_v[i] = rr_clk - sh_burst[i];
							remain[i] = '0;
						end
					end
				end
			end
		end else begin
			prefix = 0;
			for (int i = 0; i < sh_count; i++) begin
				wait_v[i] = prefix[20:0];
				prefix += sh_burst[i];
			end
		end
		tw = 0;
		tt = 0;
		for (int i = 0; i < sh_count; i++) begin
			ta = wait_v[i] + sh_burst[i];
			tw += wait_v[i];
			tt += wait_v[i] + sh_burst[i];
			r.slot = i[3:0];
			r.proc_burst = sh_burst[i];
			r.wait_res = wait_v[i][19:0];
			r.turnaround = ta[19:0];
			r.total_wait = tw[23:0];
			r.total_turnaround = tt[23:0];
			r.overflow = sh_dropped;
			r.last_result = (i + 1 == sh_count);
			sched_expect_q.push_back(r);
		end
		sh_count = 0;
		sh_dropped = 1'b0;
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	// Mark the offered request as taken; the driver refills at the falling edge.
	bit in_taken;
	task automatic in_valid_drop();
		in_taken = 1'b1;
	endtask

	// Sample both handshakes at the rising edge.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			sched_predict(in_data);
			send_gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
			in_valid_drop();
		end
		if (arst_n && out_valid && out_ready) begin
			if (sched_expect_q.size() == 0) begin
				$error("result with no expectation: slot %0d", out_data.slot);
				errors++;
			end else begin
				out_t e;
				e = sched_expect_q.pop_front();
				check_field("slot", int'(e.slot), int'(out_data.slot));
				check_field("proc_burst", int'(e.proc_burst), int'(out_data.proc_burst));
				check_field("wait_res", int'(e.wait_res), int'(out_data.wait_res));
				check_field("turnaround", int'(e.turnaround), int'(out_data.turnaround));
				check_field("total_wait", int'(e.total_wait), int'(out_data.total_wait));
				check_field("total_turnaround", int'(e.total_turnaround),
					int'(out_data.total_turnaround));
				check_field("overflow", int'(e.overflow), int'(out_data.overflow));
				check_field("last_result", int'(e.last_result),
					int'(out_data.last_result));
			end
		end
	end

	// Driver: advance to the next request only once the current one is taken.
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			in_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (proc_q.size() != 0) begin
				in_data <= proc_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random short stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			recv_hold = 400;
		end
		if (recv_hold > 0) begin
			recv_hold--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			recv_hold = $urandom_range(1, 8) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Write one register at the next falling edge; the caller drops the enable.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [QUANT_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_MODE)
			sh_mode = val[MODE_W-1:0];
		else
			sh_quantum = val;
	endtask

	task automatic set_config(input logic [MODE_W-1:0] m, input logic [QUANT_W-1:0] qv);
		cfg_write(CFG_MODE, QUANT_W'(m));
		cfg_write(CFG_QUANTUM, qv);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every request is taken and every result has come, then
	// let the block settle before the next register write.
	task automatic drain();
		do @(posedge clk);
		while (proc_q.size() != 0 || in_valid || sched_expect_q.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic push_proc(input logic [15:0] b, input logic [7:0] p, input bit lst);
		in_t it;
		it.burst = b;
		it.prio = p;
		it.last_proc = lst;
		proc_q.push_back(it);
		items_sent++;
	endtask

	// Queue one random set; round-robin bursts stay within eight slices so
	// the walk stays short.
	task automatic random_set(input int n);
		int cap;
		logic [15:0] b;
		cap = 65535;
		if (sh_mode == MODE_RR)
			cap = (sh_quantum == 0) ? 8 : ((sh_quantum * 8 > 65535) ? 65535 : sh_quantum * 8);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 5))
				0: b = '0;
				1: b = 16'($urandom_range(0, 3));
				default: b = 16'($urandom_range(0, cap));
			endcase
			push_proc(b,
				8'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255)),
				k == n - 1);
		end
	endtask

	initial begin
		logic [QUANT_W-1:0] qv;
		logic [MODE_W-1:0] mv;
		errors = 0;
		items_sent = 0;
		quiet = 1'b0;
		long_hold_req = 1'b0;
		send_gap = 0;
		recv_hold = 0;
		in_taken = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data = '0;
		sh_count = 0;
		sh_dropped = 1'b0;
		sh_mode = MODE_FCFS;
		sh_quantum = 16'd1;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Arrival order at reset defaults: extreme bursts and priorities,
		// a zero burst, then a full set of maximum bursts for the widest sums.
		push_proc(16'hFFFF, 8'hFF, 1'b0);
		push_proc(16'h0000, 8'h00, 1'b0);
		push_proc(16'h5A5A, 8'hA5, 1'b1);
		drain();
		// Long receiver hold-off while the next set is already offered, so the
		// input stalls behind the waiting results.
		long_hold_req = 1'b1;
		for (int k = 0; k < 16; k++)
			push_proc(16'hFFFF, 8'h00, k == 15);
		push_proc(16'd7, 8'd3, 1'b0);
		push_proc(16'd2, 8'd1, 1'b1);
		drain();
		// Capacity exceeded: two dropped requests, the last one still starts.
		set_config(MODE_SJF, 16'd1);
		random_set(18);
		drain();
		// Shortest first with ties, then priority with ties, single process.
		push_proc(16'd5, 8'd1, 1'b0);
		push_proc(16'd3, 8'd1, 1'b0);
		push_proc(16'd5, 8'd0, 1'b0);
		push_proc(16'd3, 8'd2, 1'b1);
		drain();
		set_config(MODE_PRIO, 16'd1);
		push_proc(16'd9, 8'd2, 1'b0);
		push_proc(16'd4, 8'd2, 1'b0);
		push_proc(16'd7, 8'd0, 1'b1);
		push_proc(16'd1, 8'd9, 1'b1);
		drain();
		// Round robin at widest slice, then with a zero slice (taken as one).
		set_config(MODE_RR, 16'hFFFF);
		push_proc(16'hFFFF, 8'd0, 1'b0);
		push_proc(16'd0, 8'd0, 1'b0);
		push_proc(16'hFFFF, 8'd0, 1'b1);
		drain();
		set_config(MODE_RR, 16'd0);
		push_proc(16'd3, 8'd0, 1'b0);
		push_proc(16'd0, 8'd0, 1'b0);
		push_proc(16'd5, 8'd0, 1'b1);
		drain();

		// Random phases: new settings, one to three sets each; the tail runs flat out.
		while (items_sent < 290) begin
			mv = MODE_W'($urandom_range(0, 3));
			case ($urandom_range(0, 3))
				0: qv = QUANT_W'($urandom_range(1, 4));
				1: qv = QUANT_W'($urandom_range(0, 64));
				2: qv = QUANT_W'($urandom());
				default: qv = 16'hFFFF;
			endcase
			if (items_sent > 240)
				quiet = 1'b1;
			set_config(mv, qv);
			repeat ($urandom_range(1, 3))
				random_set(($urandom_range(0, 5) == 0) ? $urandom_range(15, 19)
					: $urandom_range(1, 8));
			drain();
		end

		if (errors == 0) begin
			$display("cpu_schedule_wait_times_top test passed");
		end else begin
			$display("cpu_schedule_wait_times_top test failed");
		end
		$finish;
	end

	initial begin
		#50000000;
		$display("cpu_schedule_wait_times_top test failed");
		$finish;
	end
endmodule
`default_nettype wire
